// File: rtl/core/tea_block_cipher_macros.svh
// Assertion macros used by the checker module of the cipher block.
// Each macro expands to one labelled concurrent assertion, clocked and reset-gated.
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication.
`define TEA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tea assertion failed");

// Next-cycle implication.
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tea assertion failed");

`endif

// File: rtl/core/tea_pkg.sv
// Shared types and constants for the cipher block.
// Depends on nothing; used by the cell, the top level and the checker.
`default_nettype none

package tea_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd4;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t key0;
		word_t key1;
		word_t key2;
		word_t key3;
	} key_t;

endpackage

`default_nettype wire

// File: rtl/core/tea_cell.sv
// One half-round of the cipher, registered, with its own beat handshake.
// Depends on tea_pkg for the word and key types.
`default_nettype none

module tea_cell #(
	parameter logic [31:0] SUM_ENC     = 32'h9E37_79B9,
	parameter logic [31:0] SUM_DEC     = 32'hC6EF_3720,
	parameter bit          SECOND_HALF = 1'b0
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               decrypt,
	input  tea_pkg::key_t     keys,
	input  wire               up_valid,
	output logic              up_ready,
	input  tea_pkg::word_t    up_y,
	input  tea_pkg::word_t    up_z,
	output logic              dn_valid,
	input  wire               dn_ready,
	output tea_pkg::word_t    dn_y,
	output tea_pkg::word_t    dn_z
);
	import tea_pkg::*;

	logic  valid_q;
	word_t y_q;
	word_t z_q;
	word_t new_y;
	word_t new_z;
	logic  take;

	assign up_ready = !valid_q || dn_ready;
	assign take     = up_valid && up_ready;
	assign dn_valid = valid_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;

	always_comb begin
		logic  update_y;
		word_t src;
		word_t dst;
		word_t kl;
		word_t kr;
		word_t sum;
		word_t mix;
		word_t res;
		update_y = (decrypt == SECOND_HALF);
		src      = update_y ? up_z : up_y;
		dst      = update_y ? up_y : up_z;
		kl       = update_y ? keys.key0 : keys.key2;
		kr       = update_y ? keys.key1 : keys.key3;
		sum      = decrypt ? SUM_DEC : SUM_ENC;
		mix      = ((src << 4) + kl) ^ (src + sum) ^ ((src >> 5) + kr);
		res      = decrypt ? (dst - mix) : (dst + mix);
		new_y    = update_y ? res : up_y;
		new_z    = update_y ? up_z : res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			y_q <= new_y;
			z_q <= new_z;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tea_block_cipher.sv
// Pipelined cipher: a chain of 2*ROUND_COUNT half-round cells, one block a cycle
// unless out_ready stalls it. A block is registered in every cell in turn.
// Each cell stalls only when it is full and its successor is not ready, so gaps are absorbed.
// Reset clears the key and mode registers to zero and empties every cell.
// Depends on tea_pkg and tea_cell.
`default_nettype none

module tea_block_cipher #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [tea_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [tea_pkg::WORD_W-1:0]       cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [tea_pkg::WORD_W-1:0]       word_left,
	input  wire  [tea_pkg::WORD_W-1:0]       word_right,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [tea_pkg::WORD_W-1:0]       out_left,
	output logic [tea_pkg::WORD_W-1:0]       out_right
);
	import tea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUND_COUNT;

	key_t  keys_q;
	logic  decrypt_q;

	logic  valid_c [0:STAGES];
	logic  ready_c [0:STAGES];
	word_t y_c     [0:STAGES];
	word_t z_c     [0:STAGES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q    <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY0: keys_q.key0 <= cfg_data;
				CFG_KEY1: keys_q.key1 <= cfg_data;
				CFG_KEY2: keys_q.key2 <= cfg_data;
				CFG_KEY3: keys_q.key3 <= cfg_data;
				CFG_MODE: decrypt_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign valid_c[0] = in_valid;
	assign in_ready   = ready_c[0];
	assign y_c[0]     = word_left;
	assign z_c[0]     = word_right;

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		for (genvar h = 0; h < 2; h++) begin : g_half
			localparam int unsigned C = 2 * r + h;
			localparam logic [31:0] SUM_E = TEA_DELTA * 32'(r + 1);
			localparam logic [31:0] SUM_D = TEA_DELTA * 32'(ROUND_COUNT - r);

			tea_cell #(
				.SUM_ENC     (SUM_E),
				.SUM_DEC     (SUM_D),
				.SECOND_HALF (h == 1)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.decrypt  (decrypt_q),
				.keys     (keys_q),
				.up_valid (valid_c[C]),
				.up_ready (ready_c[C]),
				.up_y     (y_c[C]),
				.up_z     (z_c[C]),
				.dn_valid (valid_c[C+1]),
				.dn_ready (ready_c[C+1]),
				.dn_y     (y_c[C+1]),
				.dn_z     (z_c[C+1])
			);
		end
	end

	assign ready_c[STAGES] = out_ready;
	assign out_valid       = valid_c[STAGES];
	assign out_left        = y_c[STAGES];
	assign out_right       = z_c[STAGES];

endmodule

`default_nettype wire

// File: rtl/core/tea_chk.sv
// Port-level checker for the cipher block, attached to the top level by bind.
// Depends on tea_pkg and the assertion macros header.
`default_nettype none

`include "tea_block_cipher_macros.svh"

module tea_chk #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_ready,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire  [tea_pkg::WORD_W-1:0]       out_left,
	input wire  [tea_pkg::WORD_W-1:0]       out_right
);
	import tea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUND_COUNT;
	localparam int unsigned CNT_W  = $clog2(STAGES + 1);

	logic [CNT_W-1:0] flight_q;
	logic             in_beat;
	logic             out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else if (in_beat && !out_beat) begin
			flight_q <= flight_q + CNT_W'(1);
		end else if (out_beat && !in_beat) begin
			flight_q <= flight_q - CNT_W'(1);
		end
	end

	`TEA_ASSERT_NEXT(a_out_valid_held, clk, arst_n, out_valid && !out_ready, out_valid)
	`TEA_ASSERT_NEXT(a_out_data_held, clk, arst_n, out_valid && !out_ready, $stable({out_left, out_right}))
	`TEA_ASSERT_IMPLY(a_no_phantom, clk, arst_n, out_valid, flight_q != '0)
	`TEA_ASSERT_IMPLY(a_stall_full, clk, arst_n, !in_ready, out_valid && !out_ready && flight_q != '0)
	`TEA_ASSERT_IMPLY(a_full_blocks, clk, arst_n, flight_q == CNT_W'(STAGES) && !out_ready, !in_ready)

endmodule

bind tea_block_cipher tea_chk #(
	.ROUND_COUNT (ROUND_COUNT)
) u_tea_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_left   (out_left),
	.out_right  (out_right)
);

`default_nettype wire

// File: sim/tea_block_cipher_test.sv
// Self-checking bench for tea_block_cipher: a short table of directed blocks and register
// writes, then random phases of blocks under changing keys and directions, checked beat by
// beat against a TEA model held in the bench. Depends on tea_pkg and the tea_block_cipher RTL.
module tea_block_cipher_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tea_pkg::*;

	localparam int unsigned ROUNDS = 32;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_BLOCKS = 100;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE5 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

	typedef struct packed {
		word_t left;
		word_t right;
	} block_t;

	typedef enum logic {ROW_REG, ROW_BLOCK} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] index;
		word_t a;
		word_t b;
		logic typed;
		block_t result;
	} row_t;

	localparam int unsigned ROWS = 24;
	localparam row_t DIRECTED [ROWS] = '{
		'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{32'h41EA_3A0A, 32'h94BA_A940}},
		'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
		'{ROW_REG,   CFG_MODE, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h41EA_3A0A, 32'h94BA_A940, 1'b1,
			'{32'h0000_0000, 32'h0000_0000}},
		'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REG,   CFG_KEY0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_KEY1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_KEY2, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_KEY3, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h0000_0001, 32'h8000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_MODE, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REG,   CFG_SPARE5, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_SPARE7, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h0123_4567, 32'h89AB_CDEF, 1'b0, '0},
		'{ROW_REG,   CFG_KEY0, 32'h0123_4567, 32'h0000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_KEY2, 32'hDEAD_BEEF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REG,   CFG_MODE, 32'h0000_0003, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_BLOCK, CFG_KEY0, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	word_t word_left = '0;
	word_t word_right = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	word_t out_left;
	word_t out_right;

	key_t key_model = '0;
	logic decipher_model = 1'b0;
	block_t pending_blocks[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	logic calm = 1'b0;

	tea_block_cipher #(.ROUND_COUNT(ROUNDS)) i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic word_t tea_mix(word_t x, word_t s, word_t kl, word_t kr);
		return ((x << 4) + kl) ^ (x + s) ^ ((x >> 5) + kr);
	endfunction

	function automatic block_t tea_transform(word_t l, word_t r);
		word_t y = l;
		word_t z = r;
		word_t s;
		if (!decipher_model) begin
			s = '0;
			for (int n = 0; n < ROUNDS; n++) begin
				s += TEA_DELTA;
				y += tea_mix(z, s, key_model.key0, key_model.key1);
				z += tea_mix(y, s, key_model.key2, key_model.key3);
			end
		end else begin
			s = word_t'(TEA_DELTA * ROUNDS);
			for (int n = 0; n < ROUNDS; n++) begin
				z -= tea_mix(y, s, key_model.key2, key_model.key3);
				y -= tea_mix(z, s, key_model.key0, key_model.key1);
				s -= TEA_DELTA;
			end
		end
		return '{y, z};
	endfunction

	function automatic void store_register(logic [CFG_IDX_W-1:0] idx, word_t data);
		case (idx)
			CFG_KEY0: key_model.key0 = data;
			CFG_KEY1: key_model.key1 = data;
			CFG_KEY2: key_model.key2 = data;
			CFG_KEY3: key_model.key3 = data;
			CFG_MODE: decipher_model = data[0];
			default: ;
		endcase
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic void note_error(string what, word_t want, word_t got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
		end
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		store_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_block(word_t l, word_t r, logic typed, block_t result);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		word_left <= l;
		word_right <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_blocks.push_back(typed ? result : tea_transform(l, r));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		block_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_blocks.size() == 0) begin
				note_error("unexpected beat, out_left", '0, out_left);
			end else begin
				want = pending_blocks.pop_front();
				if (out_left !== want.left) note_error("out_left", want.left, out_left);
				if (out_right !== want.right) note_error("out_right", want.right, out_right);
			end
		end
		out_ready <= calm || $urandom_range(99) >= 29;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tea_block_cipher regression: fail");
			$finish;
		end
	end

	initial begin
		word_t mode_word;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				drain();
				write_register(DIRECTED[i].index, DIRECTED[i].a);
			end else begin
				push_block(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].typed,
					DIRECTED[i].result);
			end
		end

		// The first two phases take the all-zero and all-one keys; the rest are random.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			calm <= (p == 3);
			for (int k = 0; k < 4; k++) begin
				write_register(CFG_KEY0 + CFG_IDX_W'(k),
					p == 0 ? '0 : (p == 1 ? '1 : word_t'($urandom)));
			end
			if ($urandom_range(1)) begin
				write_register(CFG_MODE + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
			end
			mode_word = $urandom;
			mode_word[0] = p[0];
			write_register(CFG_MODE, mode_word);
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				if (p == 5 && n == PHASE_BLOCKS / 2) drain();
				push_block(pick_word(), pick_word(), 1'b0, '0);
			end
		end

		drain();
		repeat (2 * ROUNDS + 16) @(posedge clk);
		if (errors == 0 && pending_blocks.size() == 0) begin
			$display("tea_block_cipher regression: pass");
		end else begin
			$display("tea_block_cipher regression: fail");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tea_pkg.sv
rtl/core/tea_cell.sv
rtl/core/tea_block_cipher.sv
rtl/core/tea_chk.sv
sim/tea_block_cipher_test.sv
